// File: rtl/core/ert_pkg.sv
// Shared types and constants of the echo request tracker.
package ert_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_YELLOW_LIMIT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RED_LIMIT    = 8'd1;

    localparam logic [15:0] YELLOW_LIMIT_RESET = 16'd15;
    localparam logic [15:0] RED_LIMIT_RESET    = 16'd40;

    // Operation codes.
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SEND   = 2'd1;
    localparam logic [1:0] OP_REPLY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [15:0] MIN_REPLY_LEN   = 16'd8;
    localparam logic [7:0]  ECHO_REPLY_KIND = 8'd0;

    // Latency classes.
    localparam logic [1:0] CLS_GREEN  = 2'd0;
    localparam logic [1:0] CLS_YELLOW = 2'd1;
    localparam logic [1:0] CLS_RED    = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] peer_address;
        logic [15:0] start_id;
        logic [15:0] reply_ident;
        logic [15:0] reply_sequence;
        logic [7:0]  reply_kind;
        logic [15:0] reply_length;
        logic [31:0] time_now;
        logic        send_ok;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  slot_used;
        logic [15:0] sequence_used;
        logic [15:0] ident_used;
        logic [3:0]  match_count;
        logic [31:0] latency;
        logic [1:0]  latency_class;
        logic [31:0] sent_total;
        logic [31:0] received_total;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic evaluate;
        logic commit;
    } t_ert_cmd;

endpackage

// File: rtl/core/ert_ctrl.sv
// Controller state machine of the echo request tracker.
module ert_ctrl
    import ert_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    output t_ert_cmd o_cmd,
    output logic     o_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_COMMIT);
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_cmd.capture  = (r_state == S_IDLE) && start;
    assign o_cmd.evaluate = (r_state == S_EVAL);
    assign o_cmd.commit   = (r_state == S_COMMIT);
    assign o_done         = r_done;

endmodule

// File: rtl/core/ert_table.sv
// Datapath of the echo request tracker: request table, counters and limits.
module ert_table
    import ert_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_ert_cmd               i_cmd,
    input  t_in_item               i_item,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output t_out_item              o_result
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);

    t_in_item    r_item;
    logic [31:0] r_addr  [TABLE_DEPTH];
    logic [15:0] r_ident [TABLE_DEPTH];
    logic [15:0] r_seq   [TABLE_DEPTH];
    logic [31:0] r_tsend [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_hit;
    logic [TABLE_DEPTH-1:0] r_empty;
    logic [15:0] r_session;
    logic [15:0] r_seqctr;
    logic [31:0] r_sent;
    logic [31:0] r_recv;
    logic [15:0] r_yellow;
    logic [15:0] r_red;
    t_out_item   r_result;

    logic             reply_elig;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] wslot;
    logic             hit_any;
    logic [IDX_W-1:0] hit_idx;
    logic [CNT_W-1:0] hit_cnt;
    logic [31:0]      hit_cnt_ext;
    logic [31:0]      slot_ext;
    logic [15:0]      n_seqctr;
    logic [31:0]      latency;
    logic [1:0]       lat_class;
    t_out_item        n_result;

    assign reply_elig = (r_item.opcode == OP_REPLY) &&
                        (r_item.reply_length >= MIN_REPLY_LEN) &&
                        (r_item.reply_kind == ECHO_REPLY_KIND);

    // Lowest empty slot, last matching slot and match count.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        hit_any    = 1'b0;
        hit_idx    = '0;
        hit_cnt    = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (!free_found && r_empty[k]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(k);
            end
            if (r_hit[k]) begin
                hit_any = 1'b1;
                hit_idx = IDX_W'(k);
            end
            hit_cnt = hit_cnt + CNT_W'(r_hit[k]);
        end
    end

    assign wslot       = free_found ? free_idx : LAST_SLOT;
    assign n_seqctr    = r_seqctr + 16'd1;
    assign hit_cnt_ext = 32'(hit_cnt);
    assign latency     = hit_any ? (r_item.time_now - r_tsend[hit_idx]) : 32'd0;

    always_comb begin
        lat_class = CLS_GREEN;
        if (hit_any) begin
            if (latency > {16'd0, r_red}) begin
                lat_class = CLS_RED;
            end else if (latency > {16'd0, r_yellow}) begin
                lat_class = CLS_YELLOW;
            end
        end
    end

    always_comb begin
        n_result = '0;
        slot_ext = '0;
        unique case (r_item.opcode)
            OP_START: begin
                n_result.ident_used = r_item.start_id;
            end
            OP_SEND: begin
                slot_ext                = 32'(wslot);
                n_result.slot_used      = slot_ext[2:0];
                n_result.sequence_used  = n_seqctr;
                n_result.ident_used     = r_session;
                n_result.sent_total     = r_item.send_ok ? (r_sent + 32'd1) : r_sent;
                n_result.received_total = r_recv;
            end
            OP_REPLY, OP_UNUSED: begin
                slot_ext                = 32'(hit_idx);
                n_result.slot_used      = slot_ext[2:0];
                n_result.ident_used     = r_session;
                n_result.match_count    = hit_cnt_ext[3:0];
                n_result.latency        = latency;
                n_result.latency_class  = lat_class;
                n_result.sent_total     = r_sent;
                n_result.received_total = r_recv + hit_cnt_ext;
            end
            default: begin
                n_result.ident_used = r_session;
            end
        endcase
    end

    // Item capture, compare stage and result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.evaluate) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                r_empty[k] <= (r_addr[k] == 32'd0);
                r_hit[k]   <= reply_elig && (r_addr[k] != 32'd0) &&
                              (r_addr[k] == r_item.peer_address) &&
                              (r_ident[k] == r_item.reply_ident) &&
                              (r_seq[k] == r_item.reply_sequence);
            end
        end
        if (i_cmd.commit) begin
            r_result <= n_result;
        end
    end

    // Entry addresses; zero marks an empty slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                r_addr[k] <= '0;
            end
        end else if (i_cmd.commit) begin
            if (r_item.opcode == OP_START) begin
                for (int k = 0; k < TABLE_DEPTH; k++) begin
                    r_addr[k] <= '0;
                end
            end else if (r_item.opcode == OP_SEND) begin
                if (!free_found) begin
                    for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
                        r_addr[k] <= r_addr[k+1];
                    end
                end
                r_addr[wslot] <= r_item.send_ok ? r_item.peer_address : 32'd0;
            end
        end
    end

    // Entry payload; only read behind a nonzero address.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (r_item.opcode == OP_SEND)) begin
            if (!free_found) begin
                for (int k = 0; k < TABLE_DEPTH - 1; k++) begin
                    r_ident[k] <= r_ident[k+1];
                    r_seq[k]   <= r_seq[k+1];
                    r_tsend[k] <= r_tsend[k+1];
                end
            end
            r_ident[wslot] <= r_session;
            r_seq[wslot]   <= n_seqctr;
            r_tsend[wslot] <= r_item.time_now;
        end
    end

    // Session state, counters and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session <= '0;
            r_seqctr  <= '0;
            r_sent    <= '0;
            r_recv    <= '0;
            r_yellow  <= YELLOW_LIMIT_RESET;
            r_red     <= RED_LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_YELLOW_LIMIT) begin
                    r_yellow <= i_cfg_data;
                end else if (i_cfg_index == CFG_RED_LIMIT) begin
                    r_red <= i_cfg_data;
                end
            end
            if (i_cmd.commit) begin
                unique case (r_item.opcode)
                    OP_START: begin
                        r_session <= r_item.start_id;
                        r_seqctr  <= '0;
                        r_sent    <= '0;
                        r_recv    <= '0;
                    end
                    OP_SEND: begin
                        r_seqctr <= n_seqctr;
                        r_sent   <= n_result.sent_total;
                    end
                    default: begin
                        r_recv <= n_result.received_total;
                    end
                endcase
            end
        end
    end

    assign o_result = r_result;

endmodule

// File: rtl/core/echo_request_tracker_unit.sv
// Top level of the echo request tracker.
//
//  Channel   Ports                                   Transfer
//  -------   -------------------------------------   ---------------------------------
//  command   start, busy, i_item                     start high while busy is low
//  result    o_done, o_result                        o_done high for one cycle
//  config    i_cfg_we, i_cfg_index, i_cfg_data       i_cfg_we high, no wait
//
// Every transaction passes through capture, compare and commit: the command is captured
// at the accepting edge, the table is compared in the evaluate state, and the update and
// result are committed in the commit state. The result is registered at the commit and shown
// with o_done while busy is already low, so a new command can be accepted while o_done is high.
// The controller takes no new command while it compares and commits.
// The synchronous active-low reset empties the table, clears the counters and loads
// the default limits. The receiver cannot stall, so nothing waits on the output.
module echo_request_tracker_unit
    import ert_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  t_in_item               i_item,
    output logic                   o_done,
    output t_out_item              o_result,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    // Command group from the controller into the table datapath.
    t_ert_cmd cmd;

    // The controller sequences capture, compare and commit.
    ert_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd),
        .o_done  (o_done)
    );

    // The datapath holds the request table, the session counters and the limits.
    ert_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_result)
    );

endmodule

// File: tb/sv/ert_result_checker.sv
// Predicts every result of the echo request tracker and compares it with what the block produces.
module ert_result_checker
    import ert_pkg::*;
#(
    parameter int unsigned DEPTH = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  t_in_item               i_item,
    input  logic                   i_done,
    input  t_out_item              i_result,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_checked,
    output int                     o_matched
);

    logic [31:0] slot_addr    [DEPTH];
    logic [15:0] slot_ident   [DEPTH];
    logic [15:0] slot_seq     [DEPTH];
    logic [31:0] slot_sent_at [DEPTH];

    logic [15:0] session_id;
    logic [15:0] seq_count;
    logic [31:0] sent_count;
    logic [31:0] rcvd_count;
    logic [15:0] yellow_lim;
    logic [15:0] red_lim;

    t_out_item awaited_results[$];
    t_out_item want;

    int fail_count = 0;
    int pending    = 0;
    int checked    = 0;
    int matched    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_matched    = matched;

    function automatic void clear_table();
        for (int k = 0; k < DEPTH; k++) begin
            slot_addr[k]    = '0;
            slot_ident[k]   = '0;
            slot_seq[k]     = '0;
            slot_sent_at[k] = '0;
        end
    endfunction

    // Applies one command to the table and returns the result it must produce.
    function automatic t_out_item next_tracker_result(t_in_item it);
        t_out_item r;
        int slot;
        logic hit;
        r   = '0;
        hit = 1'b0;
        case (it.opcode)
            OP_START: begin
                clear_table();
                session_id = it.start_id;
                seq_count  = '0;
                sent_count = '0;
                rcvd_count = '0;
            end
            OP_SEND: begin
                slot = 0;
                while (slot < DEPTH && slot_addr[slot] != '0)
                    slot++;
                // A full table drops its oldest entry and reuses the last slot.
                if (slot == DEPTH) begin
                    for (int k = 1; k < DEPTH; k++) begin
                        slot_addr[k-1]    = slot_addr[k];
                        slot_ident[k-1]   = slot_ident[k];
                        slot_seq[k-1]     = slot_seq[k];
                        slot_sent_at[k-1] = slot_sent_at[k];
                    end
                    slot = DEPTH - 1;
                end
                seq_count          = seq_count + 16'd1;
                slot_addr[slot]    = it.send_ok ? it.peer_address : 32'd0;
                slot_ident[slot]   = session_id;
                slot_seq[slot]     = seq_count;
                slot_sent_at[slot] = it.time_now;
                if (it.send_ok)
                    sent_count = sent_count + 32'd1;
                r.slot_used     = 3'(slot);
                r.sequence_used = seq_count;
            end
            OP_REPLY: begin
                if (it.reply_length >= MIN_REPLY_LEN && it.reply_kind == ECHO_REPLY_KIND) begin
                    for (int k = 0; k < DEPTH; k++) begin
                        if (slot_addr[k] != '0 && slot_addr[k] == it.peer_address &&
                            slot_ident[k] == it.reply_ident && slot_seq[k] == it.reply_sequence) begin
                            rcvd_count    = rcvd_count + 32'd1;
                            r.match_count = r.match_count + 4'd1;
                            r.slot_used   = 3'(k);
                            r.latency     = it.time_now - slot_sent_at[k];
                            hit           = 1'b1;
                        end
                    end
                    if (hit && r.latency > {16'd0, yellow_lim})
                        r.latency_class = CLS_YELLOW;
                    if (hit && r.latency > {16'd0, red_lim})
                        r.latency_class = CLS_RED;
                end
            end
            default: begin
            end
        endcase
        r.ident_used     = session_id;
        r.sent_total     = sent_count;
        r.received_total = rcvd_count;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_table();
            session_id = '0;
            seq_count  = '0;
            sent_count = '0;
            rcvd_count = '0;
            yellow_lim = YELLOW_LIMIT_RESET;
            red_lim    = RED_LIMIT_RESET;
            awaited_results.delete();
            pending = 0;
        end else begin
            if (i_done) begin
                if (awaited_results.size() == 0) begin
                    $error("result 0x%0h arrived with no transaction awaiting it", i_result);
                    fail_count++;
                end else begin
                    want = awaited_results.pop_front();
                    checked++;
                    if (want.match_count != '0)
                        matched++;
                    check_field("slot_used", want.slot_used, i_result.slot_used);
                    check_field("sequence_used", want.sequence_used, i_result.sequence_used);
                    check_field("ident_used", want.ident_used, i_result.ident_used);
                    check_field("match_count", want.match_count, i_result.match_count);
                    check_field("latency", want.latency, i_result.latency);
                    check_field("latency_class", want.latency_class, i_result.latency_class);
                    check_field("sent_total", want.sent_total, i_result.sent_total);
                    check_field("received_total", want.received_total, i_result.received_total);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_YELLOW_LIMIT: yellow_lim = i_cfg_data;
                    CFG_RED_LIMIT:    red_lim    = i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_start && !i_busy)
                awaited_results.push_back(next_tracker_result(i_item));
            pending = awaited_results.size();
        end
    end

endmodule

// File: tb/sv/echo_request_tracker_unit_tb.sv
// Testbench top: drives commands and limit writes into the echo request tracker and gives the verdict.
module echo_request_tracker_unit_tb;
    import ert_pkg::*;

    localparam int unsigned DEPTH       = 8;
    localparam int unsigned GAP_PERCENT = 21;

    // Indexes that name no register; writes to them must leave the limits alone.
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_SUCH_REG = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOP_INDEX   = 8'hFF;

    // One request that went out successfully, kept so that replies can answer it.
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] seq;
        logic [31:0] sent_at;
    } t_sent_req;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    t_in_item               cmd_item;
    logic                   done;
    t_out_item              result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int fail_count;
    int pending;
    int checked;
    int matched;

    // The stimulus keeps its own light view of the session so that it can build replies
    // that really hit the table; it plays no part in checking.
    logic [15:0] session_id;
    logic [15:0] seq_count;
    logic [15:0] yellow_set;
    logic [15:0] red_set;
    logic [31:0] clock_now;
    logic [31:0] peers [4];
    t_sent_req   open_reqs[$];
    logic        steady;

    int n_starts  = 0;
    int n_sends   = 0;
    int n_replies = 0;
    int n_other   = 0;
    int n_limits  = 0;

    echo_request_tracker_unit #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (cmd_item),
        .o_done     (done),
        .o_result   (result),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    ert_result_checker #(
        .DEPTH(DEPTH)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_item      (cmd_item),
        .i_done      (done),
        .i_result    (result),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_matched   (matched)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Every field starts random, so that bits the block should ignore are exercised too.
    function automatic t_in_item noisy_item(logic [1:0] op);
        t_in_item it;
        it.opcode         = op;
        it.peer_address   = $urandom;
        it.start_id       = 16'($urandom);
        it.reply_ident    = 16'($urandom);
        it.reply_sequence = 16'($urandom);
        it.reply_kind     = 8'($urandom);
        it.reply_length   = 16'($urandom);
        it.time_now       = $urandom;
        it.send_ok        = 1'($urandom);
        return it;
    endfunction

    // Mostly a few fixed peers, so that the table holds several entries for one address.
    function automatic logic [31:0] pick_peer();
        if ($urandom_range(0, 99) < 85)
            return peers[$urandom_range(0, 3)];
        return $urandom;
    endfunction

    // Latencies cluster on the class boundaries of the limits currently written.
    function automatic logic [31:0] pick_latency();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 3));
            1: return 32'(yellow_set) + 32'($urandom_range(0, 1));
            2: return 32'(red_set) - 32'd1 + 32'($urandom_range(0, 2));
            3: return 32'($urandom_range(0, 2 * red_set + 60));
            4: return $urandom;
            default: return 32'($urandom_range(0, 100));
        endcase
    endfunction

    // Presents one transaction from the falling edge on, possibly after some idle cycles,
    // and returns at the rising edge that accepts it. Start stays high on return, so the
    // next transaction can follow without a gap.
    task automatic issue(t_in_item it);
        t_sent_req rec;
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < GAP_PERCENT) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        cmd_item = it;
        start    = 1'b1;
        do @(posedge i_clk); while (busy);
        case (it.opcode)
            OP_START: begin
                session_id = it.start_id;
                seq_count  = '0;
                open_reqs.delete();
                n_starts++;
            end
            OP_SEND: begin
                seq_count = seq_count + 16'd1;
                if (it.send_ok && it.peer_address != '0) begin
                    rec.addr    = it.peer_address;
                    rec.seq     = seq_count;
                    rec.sent_at = it.time_now;
                    open_reqs.push_back(rec);
                    if (open_reqs.size() > DEPTH + 4)
                        void'(open_reqs.pop_front());
                end
                n_sends++;
            end
            OP_REPLY: n_replies++;
            default:  n_other++;
        endcase
    endtask

    task automatic open_session(logic [15:0] id);
        t_in_item it;
        it          = noisy_item(OP_START);
        it.start_id = id;
        issue(it);
    endtask

    task automatic send_req(logic [31:0] addr, logic ok);
        t_in_item it;
        it              = noisy_item(OP_SEND);
        clock_now       = clock_now + 32'($urandom_range(1, 12));
        it.peer_address = addr;
        it.send_ok      = ok;
        it.time_now     = clock_now;
        issue(it);
    endtask

    task automatic answer(t_sent_req rec, logic [31:0] lat, logic [7:0] kind, logic [15:0] len);
        t_in_item it;
        it                = noisy_item(OP_REPLY);
        it.peer_address   = rec.addr;
        it.reply_ident    = session_id;
        it.reply_sequence = rec.seq;
        it.reply_kind     = kind;
        it.reply_length   = len;
        it.time_now       = rec.sent_at + lat;
        issue(it);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        if (idx == CFG_YELLOW_LIMIT)
            yellow_set = data;
        else if (idx == CFG_RED_LIMIT)
            red_set = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // Holds the sender off until every transaction has produced its result, then lets
    // the pipeline run empty before anything else happens.
    task automatic settle();
        @(negedge i_clk);
        start = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic set_limits(logic [15:0] yellow, logic [15:0] red);
        settle();
        write_reg(CFG_YELLOW_LIMIT, yellow);
        write_reg(CFG_RED_LIMIT, red);
        n_limits++;
    endtask

    // One random transaction. Most are sends and well-formed replies to recent requests, not
    // all still in the table; the rest are replies broken in one field, the unused opcode,
    // the odd new session and fully random commands.
    task automatic random_command();
        int pick;
        t_sent_req rec;
        t_in_item it;
        pick = $urandom_range(0, 99);
        rec  = '0;
        if (open_reqs.size() != 0)
            rec = open_reqs[$urandom_range(0, open_reqs.size() - 1)];
        if (pick < 3) begin
            open_session(16'($urandom));
        end else if (pick < 45 || open_reqs.size() == 0) begin
            send_req(pick_peer(), $urandom_range(0, 9) != 0);
        end else if (pick < 80) begin
            answer(rec, pick_latency(), ECHO_REPLY_KIND, 16'($urandom_range(8, 1500)));
        end else if (pick < 88) begin
            it                = noisy_item(OP_REPLY);
            it.peer_address   = rec.addr;
            it.reply_ident    = session_id;
            it.reply_sequence = rec.seq;
            it.reply_kind     = ECHO_REPLY_KIND;
            it.reply_length   = 16'($urandom_range(8, 1500));
            it.time_now       = rec.sent_at + pick_latency();
            case ($urandom_range(0, 4))
                0: it.reply_ident    ^= 16'(1 << $urandom_range(0, 15));
                1: it.reply_sequence += 16'd1;
                2: it.peer_address   ^= 32'(1) << $urandom_range(0, 31);
                3: it.reply_kind      = 8'($urandom_range(1, 255));
                default: it.reply_length = 16'($urandom_range(0, 7));
            endcase
            issue(it);
        end else if (pick < 93) begin
            issue(noisy_item(OP_UNUSED));
        end else begin
            issue(noisy_item(2'($urandom_range(0, 3))));
        end
    endtask

    initial begin
        t_in_item it;
        int w;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        cmd_item   = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        steady     = 1'b0;
        session_id = '0;
        seq_count  = '0;
        yellow_set = YELLOW_LIMIT_RESET;
        red_set    = RED_LIMIT_RESET;
        clock_now  = $urandom;
        for (int k = 0; k < 4; k++)
            peers[k] = $urandom_range(1, 32'hFFFF_FFFF);

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part under the reset limits. The first three replies land exactly on
        // the yellow boundary, just past it, and past the red boundary; the repeat reply
        // stamps the same entry a second time with a red-limit latency.
        open_session(16'hFFFF);
        send_req(32'hFFFF_FFFF, 1'b1);
        answer(open_reqs[$], 32'd15, ECHO_REPLY_KIND, MIN_REPLY_LEN);
        send_req(32'h0000_0001, 1'b1);
        answer(open_reqs[$], 32'd16, ECHO_REPLY_KIND, 16'hFFFF);
        send_req(peers[0], 1'b1);
        answer(open_reqs[$], 32'd41, ECHO_REPLY_KIND, 16'd64);
        answer(open_reqs[$], 32'd40, ECHO_REPLY_KIND, 16'd64);

        // A failed transmit frees its slot but still uses up a sequence number, and a send
        // to address zero leaves its slot empty, so a reply from zero finds nothing.
        send_req(peers[1], 1'b0);
        send_req(32'd0, 1'b1);
        it                = noisy_item(OP_REPLY);
        it.peer_address   = '0;
        it.reply_ident    = session_id;
        it.reply_sequence = seq_count;
        it.reply_kind     = ECHO_REPLY_KIND;
        it.reply_length   = MIN_REPLY_LEN;
        issue(it);

        // A reply one byte too short and one of another message type are both ignored,
        // as is the unused opcode.
        answer(open_reqs[$], 32'd3, ECHO_REPLY_KIND, MIN_REPLY_LEN - 16'd1);
        answer(open_reqs[$], 32'd3, 8'hFF, 16'd64);
        issue(noisy_item(OP_UNUSED));

        // Nine more sends overflow the table, so the oldest entries are shifted out and
        // a reply to the very first request no longer matches.
        repeat (9) send_req(pick_peer(), 1'b1);
        answer(open_reqs[0], 32'd5, ECHO_REPLY_KIND, MIN_REPLY_LEN);
        // A reply time below the send time gives a latency that wraps around.
        answer(open_reqs[$], 32'hFFFF_FFF0, ECHO_REPLY_KIND, MIN_REPLY_LEN);

        // Extreme limits, with writes to indexes that hold no register in between.
        set_limits(16'd0, 16'hFFFF);
        write_reg(CFG_NO_SUCH_REG, 16'h0003);
        write_reg(CFG_TOP_INDEX, 16'h0001);
        send_req(peers[2], 1'b1);
        answer(open_reqs[$], 32'd0, ECHO_REPLY_KIND, MIN_REPLY_LEN);
        answer(open_reqs[$], 32'd1, ECHO_REPLY_KIND, MIN_REPLY_LEN);
        answer(open_reqs[$], 32'h0001_0000, ECHO_REPLY_KIND, MIN_REPLY_LEN);

        // Crossed limits: red is below yellow and still takes precedence.
        set_limits(16'hFFFF, 16'd0);
        send_req(peers[3], 1'b1);
        answer(open_reqs[$], 32'd0, ECHO_REPLY_KIND, MIN_REPLY_LEN);
        answer(open_reqs[$], 32'd1, ECHO_REPLY_KIND, MIN_REPLY_LEN);
        answer(open_reqs[$], 32'h0001_0000, ECHO_REPLY_KIND, MIN_REPLY_LEN);

        // Random part, one phase per limit setting. The phase with the widest limits runs
        // without any idle cycle; two phases stop halfway until the block has drained.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_limits(YELLOW_LIMIT_RESET, RED_LIMIT_RESET);
                1: set_limits(16'd0, 16'd0);
                2: set_limits(16'hFFFF, 16'hFFFF);
                3: set_limits(16'd200, 16'd50);
                4: set_limits(16'($urandom), 16'($urandom));
                default: set_limits(16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)));
            endcase
            steady = (ph == 2);
            for (int n = 0; n < 150; n++) begin
                if (n == 75 && (ph == 1 || ph == 4))
                    settle();
                random_command();
            end
            steady = 1'b0;
        end

        // Wind down: wait for the last results, with a bound, then let the pipeline run out.
        @(negedge i_clk);
        start = 1'b0;
        for (w = 0; w < 1000 && pending != 0; w++)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (pending != 0)
            $error("%0d expected results never arrived", pending);

        $display("Covered %0d transactions: %0d starts, %0d sends, %0d replies, %0d other, under %0d limit settings.",
                 n_starts + n_sends + n_replies + n_other, n_starts, n_sends, n_replies, n_other,
                 n_limits + 1);
        $display("Compared %0d results, %0d of them for a reply that matched the table.",
                 checked, matched);
        if (fail_count == 0 && pending == 0)
            $display("echo_request_tracker_unit regression: pass");
        else
            $display("echo_request_tracker_unit regression: fail");
        $finish;
    end

    // Guard against a hung handshake; the slowest correct run needs well under a tenth of this.
    initial begin
        #100_000_000;
        $display("echo_request_tracker_unit regression: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/core/ert_pkg.sv
rtl/core/ert_ctrl.sv
rtl/core/ert_table.sv
rtl/core/echo_request_tracker_unit.sv
tb/sv/ert_result_checker.sv
tb/sv/echo_request_tracker_unit_tb.sv
